// ===== hdl/shac_pkg.sv =====
// Shared types and constants for the stepper axis homing controller.
// No dependencies; every other file in hdl/ but shac_fifo and shac_chk imports this package.
`default_nettype none

package shac_pkg;

  // Item modes
  localparam logic [2:0] MODE_TICK      = 3'd0;
  localparam logic [2:0] MODE_HOME      = 3'd1;
  localparam logic [2:0] MODE_MOVE_DIST = 3'd2;
  localparam logic [2:0] MODE_MOVE_UP   = 3'd3;
  localparam logic [2:0] MODE_MOVE_DOWN = 3'd4;
  localparam logic [2:0] MODE_TORQUE    = 3'd5;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_MM = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SW_OFFSET    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE       = 3'd3;
  localparam int CFG_DATA_W = 24;

  // Register reset values
  localparam logic [15:0] RST_STEPS_PER_MM = 16'd1280;
  localparam logic [11:0] RST_MAX_DIST     = 12'd300;
  localparam logic [7:0]  RST_SW_OFFSET    = 8'd5;
  localparam logic [23:0] RST_SETTLE       = 24'd500;

  // Field widths
  localparam int STEPS_W  = 20;   // steps_left and reported position
  localparam int SETTLE_W = 24;
  localparam int OFFS_W   = 16;   // switch offset in steps

  // Defaults for top-level parameters
  localparam int POSITION_BITS_DEF = 20;
  localparam int QUEUE_DEPTH_DEF   = 4;

  // Classified item handed from the front to the back
  typedef struct packed {
    logic [2:0]         mode;
    logic [STEPS_W-1:0] mag;          // relative move magnitude in steps
    logic               neg;          // clockwise, nonzero move
    logic               torque_on;
    logic               limit_switch;
  } cmd_t;

  // Result item
  typedef struct packed {
    logic                      step_pulse;
    logic                      direction_cw;
    logic                      driver_enable;
    logic signed [STEPS_W-1:0] position_steps;
    logic                      busy_res;
    logic                      rejected;
    logic                      motion_done;
  } res_t;

endpackage

`default_nettype wire

// ===== hdl/shac_cfg.sv =====
// Configuration registers and the step counts derived from them.
// Depends on shac_pkg.
`default_nettype none

module shac_cfg #(
  parameter int POSITION_BITS = shac_pkg::POSITION_BITS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [shac_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [shac_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic [15:0]                              steps_per_mm_o,
  output logic [shac_pkg::SETTLE_W-1:0]            settle_ticks_o,
  output logic signed [POSITION_BITS-1:0]          max_steps_o,
  output logic [shac_pkg::OFFS_W-1:0]              offset_steps_o
);
  import shac_pkg::*;

  localparam int CW = ((POSITION_BITS > 21) ? POSITION_BITS : 21) + 1;

  logic [15:0]         spm_r;
  logic [11:0]         max_mm_r;
  logic [7:0]          offs_mm_r;
  logic [SETTLE_W-1:0] settle_r;

  logic signed [POSITION_BITS-1:0] max_steps_r, max_steps_nxt;
  logic [OFFS_W-1:0]               offs_steps_r, offs_steps_nxt;

  logic [27:0]   max_prod;
  logic [23:0]   offs_prod;
  logic [CW-1:0] max_ext;
  logic [CW-1:0] pos_lim;

  assign cfg_ready = 1'b1;

  // Write registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spm_r     <= RST_STEPS_PER_MM;
      max_mm_r  <= RST_MAX_DIST;
      offs_mm_r <= RST_SW_OFFSET;
      settle_r  <= RST_SETTLE;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_STEPS_PER_MM: spm_r     <= cfg_wdata[15:0];
        CFG_MAX_DIST:     max_mm_r  <= cfg_wdata[11:0];
        CFG_SW_OFFSET:    offs_mm_r <= cfg_wdata[7:0];
        CFG_SETTLE:       settle_r  <= cfg_wdata[SETTLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Convert millimetres to steps, clamp the travel bound to the position range
  always_comb begin
    max_prod       = 28'(max_mm_r) * 28'(spm_r);
    offs_prod      = 24'(offs_mm_r) * 24'(spm_r);
    max_ext        = CW'(max_prod[27:8]);
    pos_lim        = {{(CW-POSITION_BITS+1){1'b0}}, {(POSITION_BITS-1){1'b1}}};
    max_steps_nxt  = (max_ext > pos_lim) ? POSITION_BITS'(pos_lim)
                                         : POSITION_BITS'(max_ext);
    offs_steps_nxt = offs_prod[23:8];
  end

  always_ff @(posedge clk) begin
    max_steps_r  <= max_steps_nxt;
    offs_steps_r <= offs_steps_nxt;
  end

  assign steps_per_mm_o = spm_r;
  assign settle_ticks_o = settle_r;
  assign max_steps_o    = max_steps_r;
  assign offset_steps_o = offs_steps_r;

endmodule

`default_nettype wire

// ===== hdl/shac_fifo.sv =====
// Small first-in first-out queue of packed words.
// Depends on nothing but the caller's word width.
`default_nettype none

module shac_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         push,
  input  wire logic [W-1:0] wdata,
  output logic              full,
  input  wire logic         pop,
  output logic [W-1:0]      rdata,
  output logic              empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    slot_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0] count_r;
  logic            do_push, do_pop;

  assign full    = (count_r == CNTW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rdata   = slot_r[rd_ptr_r];

  // Store incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= wdata;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/shac_front.sv =====
// Front stage: takes input items, converts a relative move to steps.
// Depends on shac_pkg; feeds the command queue.
`default_nettype none

module shac_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire logic [2:0]         mode,
  input  wire logic signed [12:0] distance_mm,
  input  wire logic               torque_on,
  input  wire logic               limit_switch,
  input  wire logic [15:0]        steps_per_mm,
  input  wire logic               q_full,
  output logic                    q_push,
  output shac_pkg::cmd_t          q_data
);
  import shac_pkg::*;

  logic               f_valid_r, f_valid_nxt;
  logic [2:0]         mode_r;
  logic signed [12:0] dist_r;
  logic               torque_r, sw_r;
  logic               accept;
  logic [12:0]        dist_mag;
  logic [28:0]        prod;

  assign full        = f_valid_r & q_full;
  assign accept      = push & ~full;
  assign q_push      = f_valid_r & ~q_full;
  assign f_valid_nxt = accept | (f_valid_r & q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else begin
      f_valid_r <= f_valid_nxt;
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= mode;
      dist_r   <= distance_mm;
      torque_r <= torque_on;
      sw_r     <= limit_switch;
    end
  end

  // Scale the magnitude by Q8.8 steps per mm, keep the sign aside
  always_comb begin
    dist_mag            = dist_r[12] ? 13'(-dist_r) : 13'(dist_r);
    prod                = 29'(dist_mag) * 29'(steps_per_mm);
    q_data.mode         = mode_r;
    q_data.mag          = prod[27:8];
    q_data.neg          = dist_r[12] & (prod[27:8] != '0);
    q_data.torque_on    = torque_r;
    q_data.limit_switch = sw_r;
  end

endmodule

`default_nettype wire

// ===== hdl/shac_back.sv =====
// Back stage: axis state machine, one item per cycle while r_full is low.
// Depends on shac_pkg; reads the command queue, writes the result queue.
`default_nettype none

module shac_back #(
  parameter int POSITION_BITS = shac_pkg::POSITION_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               q_empty,
  input  wire shac_pkg::cmd_t                     cmd,
  output logic                                    q_pop,
  input  wire logic                               r_full,
  output logic                                    r_push,
  output shac_pkg::res_t                          res,
  input  wire logic [shac_pkg::SETTLE_W-1:0]      settle_ticks,
  input  wire logic signed [POSITION_BITS-1:0]    max_steps,
  input  wire logic [shac_pkg::OFFS_W-1:0]        offset_steps
);
  import shac_pkg::*;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_HOMING = 2'd1;
  localparam logic [1:0] PH_SETTLE = 2'd2;
  localparam logic [1:0] PH_MOVING = 2'd3;

  localparam int P  = POSITION_BITS;
  localparam int DW = ((P > 19) ? P : 19) + 2;

  logic [1:0]          phase_r, phase_nxt;
  logic                homed_r, homed_nxt;
  logic                dir_cw_r, dir_cw_nxt;
  logic signed [P-1:0] position_r, position_nxt;
  logic [STEPS_W-1:0]  steps_left_r, steps_left_nxt;
  logic [SETTLE_W-1:0] settle_r, settle_nxt;
  logic                enable_r, enable_nxt;

  logic                fire;
  logic                pulse, rej, done;
  logic signed [P-1:0] pos_max, pos_min, pos_step;
  logic signed [DW-1:0] base, delta;
  logic [DW-1:0]       rel_mag;
  logic [STEPS_W-1:0]  mv_mag;
  logic                mv_neg;
  logic signed [32:0]  pos_wide;

  assign fire   = ~q_empty & ~r_full;
  assign q_pop  = fire;
  assign r_push = fire;

  // One step in the current direction, held at the ends of the range
  always_comb begin
    pos_max = {1'b0, {(P-1){1'b1}}};
    pos_min = {1'b1, {(P-1){1'b0}}};
    if (dir_cw_r) begin
      pos_step = (position_r == pos_min) ? position_r : position_r - P'(1);
    end else begin
      pos_step = (position_r == pos_max) ? position_r : position_r + P'(1);
    end
  end

  // Move length and direction for a command
  always_comb begin
    base    = (cmd.mode == MODE_MOVE_UP) ? DW'(offset_steps) : DW'(max_steps);
    delta   = base - DW'(position_r);
    rel_mag = delta[DW-1] ? DW'(-delta) : DW'(delta);
    if (cmd.mode == MODE_MOVE_DIST) begin
      mv_mag = cmd.mag;
      mv_neg = cmd.neg;
    end else begin
      mv_mag = (|rel_mag[DW-1:STEPS_W]) ? {STEPS_W{1'b1}} : rel_mag[STEPS_W-1:0];
      mv_neg = delta[DW-1];
    end
  end

  // Next state for the item at the head of the queue
  always_comb begin
    phase_nxt      = phase_r;
    homed_nxt      = homed_r;
    dir_cw_nxt     = dir_cw_r;
    position_nxt   = position_r;
    steps_left_nxt = steps_left_r;
    settle_nxt     = settle_r;
    enable_nxt     = enable_r;
    pulse          = 1'b0;
    rej            = 1'b0;
    done           = 1'b0;
    if (fire) begin
      if (cmd.mode == MODE_TICK) begin
        case (phase_r)
          PH_HOMING: begin
            if (cmd.limit_switch) begin
              position_nxt = '0;
              enable_nxt   = 1'b0;
              settle_nxt   = settle_ticks;
              phase_nxt    = PH_SETTLE;
            end else begin
              pulse = 1'b1;
            end
          end
          PH_SETTLE: begin
            if (settle_r == '0) begin
              // back off from the switch
              dir_cw_nxt     = 1'b0;
              steps_left_nxt = STEPS_W'(offset_steps);
              if (offset_steps == '0) begin
                enable_nxt = 1'b0;
                phase_nxt  = PH_IDLE;
                done       = 1'b1;
              end else begin
                enable_nxt = 1'b1;
                phase_nxt  = PH_MOVING;
              end
            end else begin
              settle_nxt = settle_r - 1'b1;
            end
          end
          PH_MOVING: begin
            if (pos_step >= max_steps) begin
              position_nxt   = max_steps;
              enable_nxt     = 1'b0;
              phase_nxt      = PH_IDLE;
              steps_left_nxt = '0;
              done           = 1'b1;
            end else if (cmd.limit_switch && dir_cw_r) begin
              position_nxt   = '0;
              enable_nxt     = 1'b0;
              phase_nxt      = PH_IDLE;
              steps_left_nxt = '0;
              done           = 1'b1;
            end else begin
              position_nxt   = pos_step;
              pulse          = 1'b1;
              steps_left_nxt = steps_left_r - 1'b1;
              if (steps_left_r == STEPS_W'(1)) begin
                enable_nxt = 1'b0;
                phase_nxt  = PH_IDLE;
                done       = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end else if (phase_r == PH_IDLE) begin
        case (cmd.mode)
          MODE_HOME: begin
            homed_nxt  = 1'b1;
            dir_cw_nxt = 1'b1;
            enable_nxt = 1'b1;
            phase_nxt  = PH_HOMING;
          end
          MODE_TORQUE: begin
            enable_nxt = cmd.torque_on;
          end
          MODE_MOVE_DIST, MODE_MOVE_UP, MODE_MOVE_DOWN: begin
            if (!homed_r) begin
              rej = 1'b1;
            end else begin
              dir_cw_nxt     = mv_neg;
              steps_left_nxt = mv_mag;
              if (mv_mag == '0) begin
                enable_nxt = 1'b0;
                phase_nxt  = PH_IDLE;
                done       = 1'b1;
              end else begin
                enable_nxt = 1'b1;
                phase_nxt  = PH_MOVING;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      homed_r      <= 1'b0;
      dir_cw_r     <= 1'b0;
      position_r   <= '0;
      steps_left_r <= '0;
      settle_r     <= '0;
      enable_r     <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      homed_r      <= homed_nxt;
      dir_cw_r     <= dir_cw_nxt;
      position_r   <= position_nxt;
      steps_left_r <= steps_left_nxt;
      settle_r     <= settle_nxt;
      enable_r     <= enable_nxt;
    end
  end

  // Pack the result, position reported in 20 bits
  always_comb begin
    pos_wide           = 33'(position_nxt);
    res.step_pulse     = pulse;
    res.direction_cw   = dir_cw_nxt;
    res.driver_enable  = enable_nxt;
    res.position_steps = pos_wide[STEPS_W-1:0];
    res.busy_res       = (phase_nxt != PH_IDLE);
    res.rejected       = rej;
    res.motion_done    = done;
  end

endmodule

`default_nettype wire

// ===== hdl/stepper_axis_homing_controller.sv =====
// Top level of the stepper axis homing controller.
// Depends on shac_pkg, shac_cfg, shac_front, shac_fifo and shac_back.
//
// Usage:
//   Input channel (in_push / in_full) carries one item: a tick with the limit
//   switch level, or a command (home, relative move, move up, move down,
//   torque). Every item yields exactly one result item on the output channel
//   (out_empty / out_pop), in order.
//   Configuration port (cfg_valid / cfg_ready, always ready) writes the four
//   registers by index; write only while no item is in flight.
//   Path: an accepted item passes the front register, the command queue and
//   the result queue before its result shows on the output channel.
//   Throughput: one item per cycle while the result queue has room; the back
//   stage state machine finishes each item as it pops it, so only the result queue filling limits the rate.
//   Receiver stall: results wait in the result queue, then the command queue
//   fills and in_full rises; nothing is dropped.
//   Reset (rst_n low, synchronous): queues empty, axis idle, not homed,
//   position zero, driver off, registers back to their defaults.
`default_nettype none

module stepper_axis_homing_controller #(
  parameter int POSITION_BITS = shac_pkg::POSITION_BITS_DEF,
  parameter int QUEUE_DEPTH   = shac_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input channel
  input  wire logic                            in_push,
  output logic                                 in_full,
  input  wire logic [2:0]                      in_mode,
  input  wire logic signed [12:0]              in_distance_mm,
  input  wire logic                            in_torque_on,
  input  wire logic                            in_limit_switch,
  // result channel
  output logic                                 out_empty,
  input  wire logic                            out_pop,
  output logic                                 out_step_pulse,
  output logic                                 out_direction_cw,
  output logic                                 out_driver_enable,
  output logic signed [19:0]                   out_position_steps,
  output logic                                 out_busy_res,
  output logic                                 out_rejected,
  output logic                                 out_motion_done,
  // configuration
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [shac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [shac_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import shac_pkg::*;

  logic [15:0]                     spm;
  logic [SETTLE_W-1:0]             settle_ticks;
  logic signed [POSITION_BITS-1:0] max_steps;
  logic [OFFS_W-1:0]               offset_steps;

  logic cq_push, cq_full, cq_pop, cq_empty;
  logic rq_push, rq_full;
  cmd_t cq_wdata, cq_rdata;
  res_t rq_wdata, rq_rdata;

  shac_cfg #(
    .POSITION_BITS(POSITION_BITS)
  ) u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .steps_per_mm_o(spm),
    .settle_ticks_o(settle_ticks),
    .max_steps_o   (max_steps),
    .offset_steps_o(offset_steps)
  );

  shac_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (in_push),
    .full        (in_full),
    .mode        (in_mode),
    .distance_mm (in_distance_mm),
    .torque_on   (in_torque_on),
    .limit_switch(in_limit_switch),
    .steps_per_mm(spm),
    .q_full      (cq_full),
    .q_push      (cq_push),
    .q_data      (cq_wdata)
  );

  shac_fifo #(
    .W    ($bits(cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_cmd_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (cq_push),
    .wdata(cq_wdata),
    .full (cq_full),
    .pop  (cq_pop),
    .rdata(cq_rdata),
    .empty(cq_empty)
  );

  shac_back #(
    .POSITION_BITS(POSITION_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_empty     (cq_empty),
    .cmd         (cq_rdata),
    .q_pop       (cq_pop),
    .r_full      (rq_full),
    .r_push      (rq_push),
    .res         (rq_wdata),
    .settle_ticks(settle_ticks),
    .max_steps   (max_steps),
    .offset_steps(offset_steps)
  );

  shac_fifo #(
    .W    ($bits(res_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_res_q (
    .clk  (clk),
    .rst_n(rst_n),
    .push (rq_push),
    .wdata(rq_wdata),
    .full (rq_full),
    .pop  (out_pop),
    .rdata(rq_rdata),
    .empty(out_empty)
  );

  // Drive the result ports from the queue head
  assign out_step_pulse     = rq_rdata.step_pulse;
  assign out_direction_cw   = rq_rdata.direction_cw;
  assign out_driver_enable  = rq_rdata.driver_enable;
  assign out_position_steps = rq_rdata.position_steps;
  assign out_busy_res       = rq_rdata.busy_res;
  assign out_rejected       = rq_rdata.rejected;
  assign out_motion_done    = rq_rdata.motion_done;

endmodule

`default_nettype wire

// ===== hdl/shac_chk.sv =====
// Port-level checks for the stepper axis homing controller, bound to the top.
// Depends on stepper_axis_homing_controller.
`default_nettype none

module shac_chk (
  input wire logic                            clk,
  input wire logic                            rst_n,
  input wire logic                            out_empty,
  input wire logic                            out_pop,
  input wire logic                            out_step_pulse,
  input wire logic                            out_driver_enable,
  input wire logic signed [19:0]              out_position_steps,
  input wire logic                            out_busy_res,
  input wire logic                            out_rejected,
  input wire logic                            out_motion_done
);

  // Reset empties the result queue
  assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // A refused move happens only at rest and leaves the axis at rest
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_rejected) |->
      (!out_busy_res && !out_step_pulse && !out_motion_done))
    else $error("rejected result with motion");

  // Finishing a move always drops the driver and returns to idle
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_motion_done) |-> (!out_busy_res && !out_driver_enable))
    else $error("motion done while busy or driver on");

  // A waiting result stays and holds its position
  assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_position_steps)))
    else $error("waiting result changed");

endmodule

bind stepper_axis_homing_controller shac_chk u_chk (.*);

`default_nettype wire
